// ----- rtl/gcc_pkg.sv -----
// Types, codes and calendar tables for the Gregorian calendar counter.
// Stand-alone package; used by every module in rtl/.
package gcc_pkg;

   typedef enum logic [1:0] {
      MODE_QUERY = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_NEXT  = 2'd2,
      MODE_PREV  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_LOAD = 2'd1,
      ST_LIMIT    = 2'd2
   } status_type;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int WDAY_W  = 3;
   localparam int YLO_W   = 7;

   // floor(p / 100) for p < 2^14: (p * 5243) >> 19
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   // floor(t / 7) for t < 2^15: (t * 37450) >> 18
   localparam int DIV7_MUL     = 37450;
   localparam int DIV7_SHIFT   = 18;

   localparam int QUEUE_DEPTH  = 4;

   typedef struct packed {
      mode_type             mode;
      logic                 load_ok;
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [WDAY_W-1:0]    weekday;
      logic [YLO_W-1:0]     year_lo;   // year mod 100
      logic [1:0]           cent;      // (year / 100) mod 4
   } cmd_type;

   typedef struct packed {
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [WDAY_W-1:0]    weekday;
      status_type           status;
   } rslt_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the months before m, common year
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      unique case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

// ----- rtl/gregorian_calendar_counter.sv -----
// Gregorian calendar counter with weekday: top level.
// Depends on gcc_pkg, gcc_front, gcc_queue, gcc_back.
//
//   channel   dir   beat
//   req_*     in    tuser = mode, tdata = load year/month/day
//   rsp_*     out   tuser = status, tdata = year/month/day/weekday
//
// One beat per cycle sustained while rsp_tready holds; after acceptance a request
// passes two more front stages, the queue write and the engine to the response register.
// The date engine applies one command per cycle while responses are taken; the
// front end and a four-entry queue absorb response stalls before req_tready drops.
// Reset is synchronous; the date comes up as 0001-01-01 (Monday).
module gregorian_calendar_counter import gcc_pkg::*; #(
   parameter int MAX_YEAR = 9999
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // load_year[13:0], load_month[17:14], load_day[22:18]
   input  logic [1:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cur_year, cur_month, cur_day, weekday[25:23]
   output logic [1:0]  rsp_tuser    // status
);

   logic     push_valid, push_ready;
   cmd_type  push_cmd;
   logic     pop_valid, pop_ready;
   cmd_type  pop_cmd;
   rslt_type rsp;

   gcc_front #(.MAX_YEAR(MAX_YEAR)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   gcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   gcc_back #(.MAX_YEAR(MAX_YEAR)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {6'd0, rsp.weekday, rsp.day, rsp.month, rsp.year};
   assign rsp_tuser = rsp.status;

   a_date_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.year != 14'd0) && (rsp.year <= 14'(MAX_YEAR)) &&
                     (rsp.month >= 4'd1) && (rsp.month <= 4'd12) && (rsp.day != 5'd0))
      else $error("response date out of range");

   a_wday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.weekday <= 3'd6))
      else $error("weekday out of range");

   a_limit_holds: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready && rsp_tvalid) ##1 (rsp.status == ST_LIMIT) |->
         (rsp.year == $past(rsp.year)) && (rsp.day == $past(rsp.day)))
      else $error("date moved on a limit step");

endmodule

// ----- rtl/gcc_front.sv -----
// Front end: accepts request beats, checks load dates and works out
// their weekday over three stages. Depends on gcc_pkg.
module gcc_front import gcc_pkg::*; #(
   parameter int MAX_YEAR = 9999
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,
   output logic        push_valid,
   input  logic        push_ready,
   output cmd_type     push_cmd
);

   logic advance;

   logic               a_valid_ff;
   mode_type           a_mode_ff;
   logic [YEAR_W-1:0]  a_year_ff;
   logic [MONTH_W-1:0] a_month_ff;
   logic [DAY_W-1:0]   a_day_ff;

   logic               b_valid_ff;
   mode_type           b_mode_ff;
   logic [YEAR_W-1:0]  b_year_ff;
   logic [MONTH_W-1:0] b_month_ff;
   logic [DAY_W-1:0]   b_day_ff;
   logic [YEAR_W-1:0]  b_p_ff;
   logic [7:0]         b_qp_ff;

   logic               c_valid_ff;
   mode_type           c_mode_ff;
   logic               c_ok_ff;
   logic [YEAR_W-1:0]  c_year_ff;
   logic [MONTH_W-1:0] c_month_ff;
   logic [DAY_W-1:0]   c_day_ff;
   logic [14:0]        c_total_ff;
   logic [YLO_W-1:0]   c_ylo_ff;
   logic [1:0]         c_cent_ff;

   logic [YEAR_W-1:0]  a_p;
   logic [26:0]        a_prod;
   logic [YLO_W-1:0]   b_r;
   logic               b_cent_hit;
   logic               b_leap;
   logic [DAY_W-1:0]   b_mlen;
   logic               b_ok;
   logic [14:0]        b_total;
   logic [30:0]        c_prod;
   logic [12:0]        c_q7;
   logic [WDAY_W-1:0]  c_wday;

   assign advance    = !c_valid_ff || push_ready;
   assign req_tready = advance;

   // stage a -> b: p = year - 1, p / 100
   assign a_p    = a_year_ff - 14'd1;
   assign a_prod = 27'(a_p) * 27'(DIV100_MUL);

   // stage b -> c: leap, validity, day count since epoch (mod 7 later)
   assign b_r        = 7'(b_p_ff - 14'(b_qp_ff) * 14'd100);
   assign b_cent_hit = (b_r == 7'd99);
   assign b_leap     = ((b_year_ff[1:0] == 2'd0) && !b_cent_hit) ||
                       (b_cent_hit && (b_qp_ff[1:0] == 2'b11));
   assign b_mlen     = month_len(b_month_ff, b_leap);
   assign b_ok       = (b_year_ff != 14'd0) && (b_year_ff <= 14'(MAX_YEAR)) &&
                       (b_month_ff >= 4'd1) && (b_month_ff <= 4'd12) &&
                       (b_day_ff >= 5'd1) && (b_day_ff <= b_mlen);
   assign b_total    = 15'(b_p_ff) + 15'(b_p_ff >> 2) - 15'(b_qp_ff) +
                       15'(b_qp_ff >> 2) + 15'(days_before(b_month_ff)) +
                       15'(b_leap && (b_month_ff > 4'd2)) + 15'(b_day_ff);

   // stage c: weekday = total mod 7
   assign c_prod = 31'(c_total_ff) * 31'(DIV7_MUL);
   assign c_q7   = 13'(c_prod >> DIV7_SHIFT);
   assign c_wday = 3'(c_total_ff - 15'(c_q7) * 15'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_mode_ff  <= mode_type'(req_tuser);
         a_year_ff  <= req_tdata[13:0];
         a_month_ff <= req_tdata[17:14];
         a_day_ff   <= req_tdata[22:18];

         b_mode_ff  <= a_mode_ff;
         b_year_ff  <= a_year_ff;
         b_month_ff <= a_month_ff;
         b_day_ff   <= a_day_ff;
         b_p_ff     <= a_p;
         b_qp_ff    <= 8'(a_prod >> DIV100_SHIFT);

         c_mode_ff  <= b_mode_ff;
         c_ok_ff    <= b_ok;
         c_year_ff  <= b_year_ff;
         c_month_ff <= b_month_ff;
         c_day_ff   <= b_day_ff;
         c_total_ff <= b_total;
         c_ylo_ff   <= b_cent_hit ? 7'd0 : b_r + 7'd1;
         c_cent_ff  <= b_qp_ff[1:0] + 2'(b_cent_hit);
      end
   end

   assign push_valid       = c_valid_ff;
   assign push_cmd.mode    = c_mode_ff;
   assign push_cmd.load_ok = c_ok_ff;
   assign push_cmd.year    = c_year_ff;
   assign push_cmd.month   = c_month_ff;
   assign push_cmd.day     = c_day_ff;
   assign push_cmd.weekday = c_wday;
   assign push_cmd.year_lo = c_ylo_ff;
   assign push_cmd.cent    = c_cent_ff;

endmodule

// ----- rtl/gcc_queue.sv -----
// Short command queue between front end and date engine.
// Depends on gcc_pkg.
module gcc_queue import gcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/gcc_back.sv -----
// Date engine: holds the date and weekday, applies one command per cycle unless the
// response is stalled, and drives the response register. Depends on gcc_pkg.
module gcc_back import gcc_pkg::*; #(
   parameter int MAX_YEAR = 9999
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  cmd_type  pop_cmd,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output rslt_type rsp
);

   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic [WDAY_W-1:0]  wday_ff, wday_in;
   logic [YLO_W-1:0]   ylo_ff, ylo_in;
   logic [1:0]         cent_ff, cent_in;
   status_type         status_ff, status_in;
   logic               valid_ff, valid_in;

   logic               take;
   logic               leap;
   logic [DAY_W-1:0]   mlen;
   logic [WDAY_W-1:0]  wday_up, wday_dn;

   assign pop_ready = !valid_ff || rsp_tready;
   assign take      = pop_valid && pop_ready;
   assign leap      = ((ylo_ff[1:0] == 2'd0) && (ylo_ff != 7'd0)) ||
                      ((ylo_ff == 7'd0) && (cent_ff == 2'd0));
   assign mlen      = month_len(month_ff, leap);
   assign wday_up   = (wday_ff == 3'd6) ? 3'd0 : wday_ff + 3'd1;
   assign wday_dn   = (wday_ff == 3'd0) ? 3'd6 : wday_ff - 3'd1;

   always_comb begin
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      wday_in   = wday_ff;
      ylo_in    = ylo_ff;
      cent_in   = cent_ff;
      status_in = status_ff;
      valid_in  = take ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      if (take) begin
         status_in = ST_OK;
         unique case (pop_cmd.mode)
            MODE_QUERY: begin
            end
            MODE_LOAD: begin
               if (pop_cmd.load_ok) begin
                  year_in  = pop_cmd.year;
                  month_in = pop_cmd.month;
                  day_in   = pop_cmd.day;
                  wday_in  = pop_cmd.weekday;
                  ylo_in   = pop_cmd.year_lo;
                  cent_in  = pop_cmd.cent;
               end else begin
                  status_in = ST_BAD_LOAD;
               end
            end
            MODE_NEXT: begin
               if ((year_ff >= 14'(MAX_YEAR)) && (month_ff == 4'd12) &&
                   (day_ff == 5'd31)) begin
                  status_in = ST_LIMIT;
               end else begin
                  wday_in = wday_up;
                  if (day_ff < mlen) begin
                     day_in = day_ff + 5'd1;
                  end else begin
                     day_in = 5'd1;
                     if (month_ff < 4'd12) begin
                        month_in = month_ff + 4'd1;
                     end else begin
                        month_in = 4'd1;
                        year_in  = year_ff + 14'd1;
                        if (ylo_ff == 7'd99) begin
                           ylo_in  = 7'd0;
                           cent_in = cent_ff + 2'd1;
                        end else begin
                           ylo_in = ylo_ff + 7'd1;
                        end
                     end
                  end
               end
            end
            MODE_PREV: begin
               if ((year_ff <= 14'd1) && (month_ff == 4'd1) && (day_ff == 5'd1)) begin
                  status_in = ST_LIMIT;
               end else begin
                  wday_in = wday_dn;
                  if (day_ff > 5'd1) begin
                     day_in = day_ff - 5'd1;
                  end else if (month_ff > 4'd1) begin
                     month_in = month_ff - 4'd1;
                     day_in   = month_len(month_ff - 4'd1, leap);
                  end else begin
                     month_in = 4'd12;
                     day_in   = 5'd31;
                     year_in  = year_ff - 14'd1;
                     if (ylo_ff == 7'd0) begin
                        ylo_in  = 7'd99;
                        cent_in = cent_ff - 2'd1;
                     end else begin
                        ylo_in = ylo_ff - 7'd1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // reset date 0001-01-01, a Monday
   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff   <= 14'd1;
         month_ff  <= 4'd1;
         day_ff    <= 5'd1;
         wday_ff   <= 3'd1;
         ylo_ff    <= 7'd1;
         cent_ff   <= 2'd0;
         status_ff <= ST_OK;
         valid_ff  <= 1'b0;
      end else begin
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         wday_ff   <= wday_in;
         ylo_ff    <= ylo_in;
         cent_ff   <= cent_in;
         status_ff <= status_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_tvalid  = valid_ff;
   assign rsp.year    = year_ff;
   assign rsp.month   = month_ff;
   assign rsp.day     = day_ff;
   assign rsp.weekday = wday_ff;
   assign rsp.status  = status_ff;

endmodule
